// ===== sv/c2uv_pkg.sv =====
// shared types, widths and constants for the centroid to unit vector block
`timescale 1ns / 1ps
`default_nettype none

package c2uv_pkg;

   // frame indexing
   localparam int MAX_STARS   = 1024;
   localparam int CNT_W       = $clog2(MAX_STARS);
   localparam int STAR_IDX_W  = 10;

   // field widths
   localparam int CENT_W      = 17;
   localparam int FOCAL_W     = 20;
   localparam int SIZE_W      = 14;
   localparam int UNIT_W      = 16;
   localparam int UNIT_Z_W    = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   // fixed-point scaling
   localparam int OUT_FRAC_BITS = 15;
   localparam int NORM_EXTRA    = 11;

   // datapath widths
   localparam int DIFF_W      = CENT_W + 2;
   localparam int MAG_W       = FOCAL_W;
   localparam int PROD_W      = 2 * MAG_W;
   localparam int SUMSQ_W     = PROD_W + 1;
   localparam int RAD_W       = 64;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int ROOT_STEPS  = ROOT_W;
   localparam int RREM_W      = ROOT_W + 2;
   localparam int NUM_SHIFT   = OUT_FRAC_BITS + NORM_EXTRA + 1;
   localparam int NUM_W       = MAG_W + NUM_SHIFT + 1;
   localparam int Q_W         = OUT_FRAC_BITS + 2;
   localparam int DEN_W       = ROOT_W + 1;
   localparam int DREM_W      = DEN_W + 1;
   localparam int STEP_W      = $clog2(ROOT_STEPS);
   localparam int LANES       = 3;

   // saturation limits
   localparam logic [Q_W-1:0] POS_LIMIT = Q_W'((1 << (UNIT_W - 1)) - 1);
   localparam logic [Q_W-1:0] NEG_LIMIT = Q_W'(1 << (UNIT_W - 1));
   localparam logic [Q_W-1:0] Z_LIMIT   = Q_W'((1 << UNIT_Z_W) - 1);

   // lane numbers
   localparam logic [1:0] LANE_X = 2'd0;
   localparam logic [1:0] LANE_Y = 2'd1;
   localparam logic [1:0] LANE_Z = 2'd2;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_LENGTH = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_SIZE  = 2'd1,
      STAT_ZERO_NORM = 2'd2
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      CS_IDLE,
      CS_SQUARE,
      CS_CHECK,
      CS_ROOT,
      CS_PREP,
      CS_DIVIDE,
      CS_DONE
   } ctrl_state_type;

   // configuration seen by the datapath
   typedef struct packed {
      logic [FOCAL_W-1:0] focal_length;
      logic [SIZE_W-1:0]  image_width;
      logic [SIZE_W-1:0]  image_height;
   } cfg_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       load;
      logic       sq_mul;
      logic [1:0] sq_sel;
      logic       sq_acc;
      logic       root_init;
      logic       root_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } dp_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic bad_size;
      logic zero_norm;
      logic out_free;
   } dp_stat_type;

endpackage

`default_nettype wire

// ===== sv/c2uv_ctrl.sv =====
// sequencing state machine for the centroid to unit vector block
`timescale 1ns / 1ps
`default_nettype none

module c2uv_ctrl
   import c2uv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire dp_stat_type stat,
   output      dp_cmd_type  cmd
);

   ctrl_state_type      state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;

   // state and step counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (req_valid) begin
               state_in = CS_SQUARE;
               step_in  = '0;
            end
         end
         CS_SQUARE: begin
            if (step_ff == STEP_W'(LANES)) begin
               state_in = CS_CHECK;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         CS_CHECK: begin
            if (stat.bad_size || stat.zero_norm) begin
               state_in = CS_DONE;
            end else begin
               state_in = CS_ROOT;
               step_in  = '0;
            end
         end
         CS_ROOT: begin
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = CS_PREP;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         CS_PREP: begin
            state_in = CS_DIVIDE;
            step_in  = '0;
         end
         CS_DIVIDE: begin
            if (step_ff == STEP_W'(Q_W - 1)) begin
               state_in = CS_DONE;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         CS_DONE: begin
            if (stat.out_free) begin
               state_in = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
            step_in  = '0;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != CS_IDLE);
      unique case (state_ff)
         CS_IDLE: begin
            cmd.load = req_valid;
         end
         CS_SQUARE: begin
            cmd.sq_mul = (step_ff < STEP_W'(LANES));
            cmd.sq_sel = step_ff[1:0];
            cmd.sq_acc = (step_ff != '0);
         end
         CS_CHECK: begin
            cmd.root_init = 1'b1;
         end
         CS_ROOT: begin
            cmd.root_step = 1'b1;
         end
         CS_PREP: begin
            cmd.div_init = 1'b1;
         end
         CS_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         CS_DONE: begin
            cmd.out_load = stat.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/c2uv_datapath.sv =====
// arithmetic datapath: offsets, sum of squares, square root, dividers, result register
`timescale 1ns / 1ps
`default_nettype none

module c2uv_datapath
   import c2uv_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic [CENT_W-1:0]      req_centroid_x,
   input  wire logic [CENT_W-1:0]      req_centroid_y,
   input  wire logic                   req_frame_start,
   input  wire dp_cmd_type             cmd,
   output      dp_stat_type            stat,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [STAR_IDX_W-1:0]  rsp_star_index,
   output      logic [UNIT_W-1:0]      rsp_unit_x,
   output      logic [UNIT_W-1:0]      rsp_unit_y,
   output      logic [UNIT_Z_W-1:0]    rsp_unit_z,
   output      logic [1:0]             rsp_status
);

   // per-item state
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   idx_ff;
   logic [MAG_W-1:0]   mag_ff [LANES];
   logic               neg_x_ff, neg_y_ff;
   logic               bad_size_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SUMSQ_W-1:0] acc_ff;

   // square root state
   logic [RAD_W-1:0]   rad_ff;
   logic [ROOT_W-1:0]  root_ff;
   logic [RREM_W-1:0]  rrem_ff;

   // divider lanes
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   drem_ff [LANES];
   logic [Q_W-1:0]     quo_ff  [LANES];

   // result register
   logic                  out_valid_ff;
   logic [STAR_IDX_W-1:0] out_idx_ff;
   logic [UNIT_W-1:0]     out_x_ff, out_y_ff;
   logic [UNIT_Z_W-1:0]   out_z_ff;
   status_type            out_status_ff;

   // offsets from the image centre
   logic [DIFF_W-1:0] diff_x, diff_y, negd_x, negd_y;
   logic [CNT_W-1:0]  base_idx;

   always_comb begin
      diff_x   = DIFF_W'(req_centroid_x) - DIFF_W'({cfg.image_width, 3'b000});
      diff_y   = DIFF_W'({cfg.image_height, 3'b000}) - DIFF_W'(req_centroid_y);
      negd_x   = ~diff_x + 1'b1;
      negd_y   = ~diff_y + 1'b1;
      base_idx = req_frame_start ? '0 : cnt_ff;
      cnt_in   = (base_idx == CNT_W'(MAX_STARS - 1)) ? '0 : base_idx + 1'b1;
   end

   // squarer operand select
   logic [MAG_W-1:0] sq_op;

   always_comb begin
      unique case (cmd.sq_sel)
         LANE_X:  sq_op = mag_ff[0];
         LANE_Y:  sq_op = mag_ff[1];
         LANE_Z:  sq_op = mag_ff[2];
         default: sq_op = '0;
      endcase
   end

   // square root step: two radicand bits per cycle
   logic [RREM_W+1:0] rrem_sh, rtrial;
   logic              rfit;

   always_comb begin
      rrem_sh = {rrem_ff, rad_ff[RAD_W-1 -: 2]};
      rtrial  = (RREM_W+2)'({root_ff, 2'b01});
      rfit    = (rrem_sh >= rtrial);
   end

   // divider numerators for the load step
   logic [NUM_W-1:0] num [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         num[i] = (NUM_W'(mag_ff[i]) << NUM_SHIFT) + NUM_W'(root_ff);
      end
   end

   // restoring divide step on each lane
   logic [DREM_W-1:0] dtrial [LANES];
   logic              dfit   [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         dtrial[i] = {drem_ff[i], quo_ff[i][Q_W-1]};
         dfit[i]   = (dtrial[i] >= DREM_W'(den_ff));
      end
   end

   // load, square and accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= cnt_in;
      end
      if (cmd.load) begin
         idx_ff      <= base_idx;
         mag_ff[0]   <= MAG_W'(diff_x[DIFF_W-1] ? negd_x[CENT_W-1:0] : diff_x[CENT_W-1:0]);
         mag_ff[1]   <= MAG_W'(diff_y[DIFF_W-1] ? negd_y[CENT_W-1:0] : diff_y[CENT_W-1:0]);
         mag_ff[2]   <= cfg.focal_length;
         neg_x_ff    <= diff_x[DIFF_W-1];
         neg_y_ff    <= diff_y[DIFF_W-1];
         bad_size_ff <= (cfg.image_width == '0) || (cfg.image_height == '0);
         acc_ff      <= '0;
      end else if (cmd.sq_acc) begin
         acc_ff <= acc_ff + SUMSQ_W'(prod_ff);
      end
      if (cmd.sq_mul) begin
         prod_ff <= sq_op * sq_op;
      end
   end

   // square root iterations
   always_ff @(posedge clock) begin
      if (cmd.root_init) begin
         rad_ff  <= RAD_W'(acc_ff) << (2 * NORM_EXTRA);
         root_ff <= '0;
         rrem_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (rfit) begin
            rrem_ff <= RREM_W'(rrem_sh - rtrial);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rrem_ff <= RREM_W'(rrem_sh);
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // three divider lanes share one denominator, quotient bits shift in from the right
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         den_ff <= {root_ff, 1'b0};
         for (int i = 0; i < LANES; i++) begin
            drem_ff[i] <= DEN_W'(num[i][NUM_W-1:Q_W]);
            quo_ff[i]  <= num[i][Q_W-1:0];
         end
      end else if (cmd.div_step) begin
         for (int i = 0; i < LANES; i++) begin
            if (dfit[i]) begin
               drem_ff[i] <= DEN_W'(dtrial[i] - DREM_W'(den_ff));
               quo_ff[i]  <= {quo_ff[i][Q_W-2:0], 1'b1};
            end else begin
               drem_ff[i] <= DEN_W'(dtrial[i]);
               quo_ff[i]  <= {quo_ff[i][Q_W-2:0], 1'b0};
            end
         end
      end
   end

   // rounding done by the numerator offset, here saturation, sign, status and zeroing of dropped items
   logic [Q_W-1:0]      sat_x, sat_y, sat_z;
   logic [UNIT_W-1:0]   unit_x, unit_y;
   logic [UNIT_Z_W-1:0] unit_z;
   status_type          status;

   always_comb begin
      sat_x = neg_x_ff ? ((quo_ff[0] > NEG_LIMIT) ? NEG_LIMIT : quo_ff[0])
                       : ((quo_ff[0] > POS_LIMIT) ? POS_LIMIT : quo_ff[0]);
      sat_y = neg_y_ff ? ((quo_ff[1] > NEG_LIMIT) ? NEG_LIMIT : quo_ff[1])
                       : ((quo_ff[1] > POS_LIMIT) ? POS_LIMIT : quo_ff[1]);
      sat_z = (quo_ff[2] > Z_LIMIT) ? Z_LIMIT : quo_ff[2];
      unit_x = neg_x_ff ? UNIT_W'(~sat_x + 1'b1) : UNIT_W'(sat_x);
      unit_y = neg_y_ff ? UNIT_W'(~sat_y + 1'b1) : UNIT_W'(sat_y);
      unit_z = UNIT_Z_W'(sat_z);
      priority if (bad_size_ff) begin
         status = STAT_BAD_SIZE;
      end else if (acc_ff == '0) begin
         status = STAT_ZERO_NORM;
      end else begin
         status = STAT_OK;
      end
      if (status != STAT_OK) begin
         unit_x = '0;
         unit_y = '0;
         unit_z = '0;
      end
   end

   // result register, refilled as soon as the current beat leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         out_idx_ff    <= STAR_IDX_W'(idx_ff);
         out_x_ff      <= unit_x;
         out_y_ff      <= unit_y;
         out_z_ff      <= unit_z;
         out_status_ff <= status;
      end
   end

   assign stat.bad_size  = bad_size_ff;
   assign stat.zero_norm = (acc_ff == '0);
   assign stat.out_free  = !out_valid_ff || !rsp_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_star_index = out_idx_ff;
   assign rsp_unit_x     = out_x_ff;
   assign rsp_unit_y     = out_y_ff;
   assign rsp_unit_z     = out_z_ff;
   assign rsp_status     = out_status_ff;

   // a waiting beat is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(out_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   // a dropped item carries no vector
   a_dropped_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_status_ff != STAT_OK))
         |-> (out_x_ff == '0 && out_y_ff == '0 && out_z_ff == '0))
      else $error("dropped item carries a nonzero vector");

   // frame start restarts the index at zero
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && req_frame_start) |=> (idx_ff == '0 && cnt_ff == CNT_W'(1)))
      else $error("frame start did not restart the index");

endmodule

`default_nettype wire

// ===== sv/centroid_to_unit_vector.sv =====
// top level: configuration registers, controller and datapath
//
// Turns one star centroid (Q13.4 pixels) per beat into a camera-frame unit vector, x and y in Q1.15
// and z in unsigned Q0.15, relative to the image centre, y up, z the focal length, plus a per-frame
// star index and a status code. One item is processed at a time: a valid item goes through load,
// the shared squarer, the check, the bit-serial square root, divider setup, the three parallel
// restoring dividers and hand-off to the result register; an item flagged for invalid image size
// or zero norm goes from the check straight to hand-off. The result register lets the next
// item be accepted while the previous result is still waiting on rsp_stall. Configuration
// registers reset to zero and should be written while no item is in flight.
`timescale 1ns / 1ps
`default_nettype none

module centroid_to_unit_vector
   import c2uv_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   input  wire logic                   req_valid,
   output      logic                   req_stall,
   input  wire logic [CENT_W-1:0]      req_centroid_x,
   input  wire logic [CENT_W-1:0]      req_centroid_y,
   input  wire logic                   req_frame_start,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   output      logic [STAR_IDX_W-1:0]  rsp_star_index,
   output      logic [UNIT_W-1:0]      rsp_unit_x,
   output      logic [UNIT_W-1:0]      rsp_unit_y,
   output      logic [UNIT_Z_W-1:0]    rsp_unit_z,
   output      logic [1:0]             rsp_status
);

   cfg_type     cfg_ff;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // configuration registers, writes to unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FOCAL_LENGTH: cfg_ff.focal_length <= FOCAL_W'(csr_write_data);
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= SIZE_W'(csr_write_data);
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= SIZE_W'(csr_write_data);
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // sequencer
   c2uv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // arithmetic
   c2uv_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .req_centroid_x  (req_centroid_x),
      .req_centroid_y  (req_centroid_y),
      .req_frame_start (req_frame_start),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_star_index  (rsp_star_index),
      .rsp_unit_x      (rsp_unit_x),
      .rsp_unit_y      (rsp_unit_y),
      .rsp_unit_z      (rsp_unit_z),
      .rsp_status      (rsp_status)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench for the centroid to unit vector block
`timescale 1ns / 1ps

module testbench;
   import c2uv_pkg::*;

   localparam int CENT_MAX  = (1 << CENT_W) - 1;
   localparam int FOCAL_MAX = (1 << FOCAL_W) - 1;
   localparam int SIZE_MAX  = (1 << SIZE_W) - 1;
   localparam int HOLD_LEN  = 400;

   // one centroid beat
   typedef struct {
      logic [CENT_W-1:0] cx;
      logic [CENT_W-1:0] cy;
      logic              fs;
   } centroid_beat_type;

   // one unit vector beat
   typedef struct {
      logic [STAR_IDX_W-1:0] star_index;
      logic [UNIT_W-1:0]     unit_x;
      logic [UNIT_W-1:0]     unit_y;
      logic [UNIT_Z_W-1:0]   unit_z;
      status_type            status;
   } unit_vector_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_write_data   = '0;
   logic                  req_valid        = 1'b0;
   logic                  req_stall;
   logic [CENT_W-1:0]     req_centroid_x   = '0;
   logic [CENT_W-1:0]     req_centroid_y   = '0;
   logic                  req_frame_start  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall        = 1'b0;
   logic [STAR_IDX_W-1:0] rsp_star_index;
   logic [UNIT_W-1:0]     rsp_unit_x;
   logic [UNIT_W-1:0]     rsp_unit_y;
   logic [UNIT_Z_W-1:0]   rsp_unit_z;
   logic [1:0]            rsp_status;

   centroid_to_unit_vector dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_centroid_x   (req_centroid_x),
      .req_centroid_y   (req_centroid_y),
      .req_frame_start  (req_frame_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_star_index   (rsp_star_index),
      .rsp_unit_x       (rsp_unit_x),
      .rsp_unit_y       (rsp_unit_y),
      .rsp_unit_z       (rsp_unit_z),
      .rsp_status       (rsp_status)
   );

   // clock
   always #4 clock = ~clock;

   // predictor copy of the registers and the star counter
   logic [FOCAL_W-1:0] focal_q    = '0;
   logic [SIZE_W-1:0]  width_q    = '0;
   logic [SIZE_W-1:0]  height_q   = '0;
   int unsigned        star_count = 0;

   centroid_beat_type centroid_queue[$];
   unit_vector_type   unit_vectors_due[$];
   centroid_beat_type next_beat;
   centroid_beat_type seen_beat;
   unit_vector_type   due;
   int unsigned    beats_queued = 0;
   int unsigned    beats_taken  = 0;
   int unsigned    error_count  = 0;
   bit             req_taken    = 1'b0;
   bit             idle_on      = 1'b1;
   bit             hold_request = 1'b0;
   int             hold_left    = 0;
   int             stall_left   = 0;
   int             send_gap     = 0;

   // integer square root, bit by bit
   function automatic longint unsigned square_root(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'h4000_0000_0000_0000;
      while (probe > v)
         probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // magnitude over norm in q1.15, rounded half away from zero
   function automatic longint unsigned rounded_ratio(longint unsigned mag,
                                                    longint unsigned norm);
      return ((mag << NUM_SHIFT) + norm) / (norm << 1);
   endfunction

   // signed component with saturation
   function automatic logic [UNIT_W-1:0] signed_unit(longint v, longint unsigned norm);
      longint unsigned q;
      q = rounded_ratio((v < 0) ? -v : v, norm);
      if (v < 0) begin
         if (q > NEG_LIMIT)
            q = NEG_LIMIT;
         return UNIT_W'(-q);
      end
      if (q > POS_LIMIT)
         q = POS_LIMIT;
      return UNIT_W'(q);
   endfunction

   // expected unit vector for one centroid, advances the star counter
   function automatic unit_vector_type predict_unit_vector(centroid_beat_type b);
      unit_vector_type r;
      longint          x;
      longint          y;
      longint          z;
      longint unsigned sum_sq;
      longint unsigned norm;
      longint unsigned qz;
      if (b.fs)
         star_count = 0;
      r.star_index = STAR_IDX_W'(star_count);
      star_count   = (star_count + 1) % MAX_STARS;
      r.unit_x     = '0;
      r.unit_y     = '0;
      r.unit_z     = '0;
      r.status     = STAT_OK;
      if (width_q == 0 || height_q == 0) begin
         r.status = STAT_BAD_SIZE;
      end else begin
         x      = longint'(b.cx) - 8 * longint'(width_q);
         y      = 8 * longint'(height_q) - longint'(b.cy);
         z      = longint'(focal_q);
         sum_sq = x * x + y * y + z * z;
         if (sum_sq == 0) begin
            r.status = STAT_ZERO_NORM;
         end else begin
            norm     = square_root(sum_sq << (2 * NORM_EXTRA));
            r.unit_x = signed_unit(x, norm);
            r.unit_y = signed_unit(y, norm);
            qz       = rounded_ratio(z, norm);
            if (qz > Z_LIMIT)
               qz = Z_LIMIT;
            r.unit_z = UNIT_Z_W'(qz);
         end
      end
      return r;
   endfunction

   // idle run length: mostly short, a few long
   function automatic int idle_length(bit enabled);
      int pick;
      if (!enabled)
         return 0;
      pick = $urandom_range(99);
      if (pick < 55)
         return 0;
      if (pick < 85)
         return $urandom_range(3, 1);
      if (pick < 97)
         return $urandom_range(12, 4);
      return $urandom_range(80, 20);
   endfunction

   // monitor: check result beats, predict on accepted centroid beats
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (unit_vectors_due.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected unit vector beat at %0t: idx %0d", $time, rsp_star_index);
            end else begin
               due = unit_vectors_due.pop_front();
               if (rsp_star_index !== due.star_index || rsp_unit_x !== due.unit_x ||
                   rsp_unit_y !== due.unit_y || rsp_unit_z !== due.unit_z ||
                   rsp_status !== due.status) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("mismatch at %0t: exp idx %0d x %0d y %0d z %0d st %0d, %s",
                              $time, due.star_index, $signed(due.unit_x),
                              $signed(due.unit_y), due.unit_z, due.status,
                              $sformatf("got idx %0d x %0d y %0d z %0d st %0d",
                                        rsp_star_index, $signed(rsp_unit_x),
                                        $signed(rsp_unit_y), rsp_unit_z, rsp_status));
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            beats_taken++;
            seen_beat.cx = req_centroid_x;
            seen_beat.cy = req_centroid_y;
            seen_beat.fs = req_frame_start;
            unit_vectors_due.insert(unit_vectors_due.size(),
                                    predict_unit_vector(seen_beat));
         end
      end
   end

   // driver: one centroid beat at a time, held until taken
   always @(negedge clock) begin
      if (!(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap--;
         end else if (centroid_queue.size() > 0) begin
            next_beat        = centroid_queue.pop_front();
            req_centroid_x  <= next_beat.cx;
            req_centroid_y  <= next_beat.cy;
            req_frame_start <= next_beat.fs;
            req_valid       <= 1'b1;
            send_gap         = idle_length(idle_on);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_LEN;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = idle_length(idle_on);
      end
   end

   task automatic queue_centroid(int cx, int cy, bit fs);
      centroid_beat_type b;
      b.cx = CENT_W'(cx);
      b.cy = CENT_W'(cy);
      b.fs = fs;
      centroid_queue.insert(centroid_queue.size(), b);
      beats_queued++;
   endtask

   // wait until every queued beat is taken and answered
   task automatic settle(int tail);
      do
         @(negedge clock);
      while (beats_taken != beats_queued || unit_vectors_due.size() != 0);
      repeat (tail) @(negedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         CSR_FOCAL_LENGTH: focal_q  = data[FOCAL_W-1:0];
         CSR_IMAGE_WIDTH:  width_q  = data[SIZE_W-1:0];
         CSR_IMAGE_HEIGHT: height_q = data[SIZE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // new camera geometry once the block is idle
   task automatic set_geometry(int focal, int w, int h);
      settle(12);
      write_register(CSR_FOCAL_LENGTH, focal);
      write_register(CSR_IMAGE_WIDTH, w);
      write_register(CSR_IMAGE_HEIGHT, h);
   endtask

   // random centroids: mostly inside the image, some on the axes, some anywhere
   task automatic random_centroids(int count);
      int span_x;
      int span_y;
      int pick;
      int cx;
      int cy;
      span_x = (16 * width_q > CENT_MAX) ? CENT_MAX : 16 * width_q;
      span_y = (16 * height_q > CENT_MAX) ? CENT_MAX : 16 * height_q;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         cx   = $urandom_range(span_x);
         cy   = $urandom_range(span_y);
         if (pick < 6) begin
            cx = 8 * width_q;
            cy = 8 * height_q;
         end else if (pick < 12) begin
            cx = 8 * width_q;
         end else if (pick < 18) begin
            cy = 8 * height_q;
         end else if (pick < 35) begin
            cx = $urandom_range(CENT_MAX);
            cy = $urandom_range(CENT_MAX);
         end
         queue_centroid(cx, cy, $urandom_range(19) == 0);
      end
   endtask

   // stimulus
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers still at reset, so the size is invalid
      queue_centroid(0, 0, 1);
      queue_centroid(CENT_MAX, CENT_MAX, 0);

      // zero focal length: full scale on the axes, zero norm at the center
      set_geometry(0, 640, 480);
      queue_centroid(5120, 3840, 1);
      queue_centroid(0, 3840, 0);
      queue_centroid(10240, 3840, 0);
      queue_centroid(5120, 0, 0);
      queue_centroid(5120, 7680, 0);
      queue_centroid(CENT_MAX, CENT_MAX, 0);
      queue_centroid(0, CENT_MAX, 0);

      // longest focal length: z saturates on the boresight
      set_geometry(FOCAL_MAX, 640, 480);
      queue_centroid(5120, 3840, 1);
      queue_centroid(0, 0, 0);
      queue_centroid(CENT_MAX, 0, 0);

      // largest sizes, beyond the nominal image
      set_geometry(FOCAL_MAX, SIZE_MAX, SIZE_MAX);
      queue_centroid(CENT_MAX, CENT_MAX, 0);
      queue_centroid(0, 0, 0);

      // invalid size wins over zero norm
      set_geometry(0, 0, 480);
      queue_centroid(0, 3840, 1);
      queue_centroid(77777, 12345, 0);
      set_geometry(16000, 640, 0);
      queue_centroid(5120, 0, 0);

      // one long frame of 201 beats so the star index climbs to 200
      queue_centroid($urandom_range(CENT_MAX), $urandom_range(CENT_MAX), 1);
      for (int i = 0; i < 200; i++)
         queue_centroid($urandom_range(CENT_MAX), $urandom_range(CENT_MAX), 0);

      // receiver holds off while the sender keeps offering
      set_geometry(16000, 1024, 1024);
      hold_request = 1'b1;
      random_centroids(100);

      set_geometry(FOCAL_MAX, SIZE_MAX, SIZE_MAX);
      random_centroids(60);
      set_geometry(0, 1, 1);
      random_centroids(60);
      set_geometry(0, 8192, 8192);
      random_centroids(60);
      set_geometry($urandom_range(FOCAL_MAX), 0, $urandom_range(SIZE_MAX));
      random_centroids(30);

      // random geometry, with and without idling
      for (int p = 0; p < 4; p++) begin
         set_geometry($urandom_range(FOCAL_MAX), $urandom_range(SIZE_MAX, 1),
                      $urandom_range(SIZE_MAX, 1));
         idle_on = p[0];
         random_centroids(55);
      end

      settle(70);
      if (error_count == 0 && unit_vectors_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/c2uv_pkg.sv
sv/c2uv_ctrl.sv
sv/c2uv_datapath.sv
sv/centroid_to_unit_vector.sv
tb/testbench.sv
